### hw/rtl/tcp_synack_rst_drop_filter_unit_defines.svh
// Assertion macros for the TCP SYN-ACK / RST drop filter
`ifndef TCP_SYNACK_RST_DROP_FILTER_UNIT_DEFINES_SVH
`define TCP_SYNACK_RST_DROP_FILTER_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TSRDF_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define TSRDF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tsrdf_pkg.sv
// Shared constants and verdict codes for the TCP SYN-ACK / RST drop filter
package tsrdf_pkg;

  localparam int DEFAULT_LENGTH_BITS  = 16;
  localparam int DEFAULT_COUNTER_BITS = 64;
  localparam int DEFAULT_QUEUE_DEPTH  = 4;

  // verdict codes
  localparam logic [1:0] REASON_PASS   = 2'd0;
  localparam logic [1:0] REASON_SYNACK = 2'd1;
  localparam logic [1:0] REASON_RST    = 2'd2;
  localparam int         REASON_BITS   = 2;

  // header layout, byte offsets from the destination address
  localparam int OFF_ETYPE_HI   = 12;
  localparam int OFF_ETYPE_LO   = 13;
  localparam int OFF_IHL        = 14;
  localparam int OFF_PROTO      = 23;
  localparam int ETH_HDR_BYTES  = 14;
  localparam int IP_MIN_END     = 34;
  localparam int TCP_MIN_BYTES  = 20;
  localparam int TCP_DOFF_OFF   = 12;
  localparam int TCP_FLAGS_OFF  = 13;
  localparam int TCP_START_BITS = 7;  // 14 + 4*15 fits

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
  localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;

  // TCP flag bit positions
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;

endpackage

### hw/rtl/tsrdf_parser.sv
// Front end: tracks byte offset, captures header fields, forms the verdict
module tsrdf_parser import tsrdf_pkg::*; #(
  parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output logic                   verdict_valid,
  input  logic                   verdict_ready,
  output logic [REASON_BITS-1:0] verdict_reason,
  output logic [LENGTH_BITS-1:0] verdict_len
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  logic [LENGTH_BITS-1:0]    byte_offset;
  logic [15:0]               ether_type, ether_type_next;
  logic [3:0]                ip_header_words, ip_header_words_next;
  logic [7:0]                ip_protocol, ip_protocol_next;
  logic [TCP_START_BITS-1:0] tcp_start_offset, tcp_start_offset_next;
  logic [3:0]                tcp_header_words, tcp_header_words_next;
  logic [7:0]                tcp_flag_bits, tcp_flag_bits_next;

  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] tcp_base, ip_end, tcp_min_end, tcp_end;
  logic                   accept;
  logic [1:0]             reason;

  assign accept        = byte_valid & byte_ready;
  assign byte_ready    = verdict_ready;
  assign verdict_valid = byte_valid & last_byte;

  always_comb begin
    ether_type_next       = ether_type;
    ip_header_words_next  = ip_header_words;
    ip_protocol_next      = ip_protocol;
    tcp_start_offset_next = tcp_start_offset;
    tcp_header_words_next = tcp_header_words;
    tcp_flag_bits_next    = tcp_flag_bits;
    if (byte_offset == LENGTH_BITS'(OFF_ETYPE_HI)) begin
      ether_type_next[15:8] = data_byte;
    end else if (byte_offset == LENGTH_BITS'(OFF_ETYPE_LO)) begin
      ether_type_next[7:0] = data_byte;
    end else if (byte_offset == LENGTH_BITS'(OFF_IHL)) begin
      ip_header_words_next  = data_byte[3:0];
      tcp_start_offset_next = TCP_START_BITS'(ETH_HDR_BYTES)
                            + TCP_START_BITS'({data_byte[3:0], 2'b00});
    end else if (byte_offset == LENGTH_BITS'(OFF_PROTO)) begin
      ip_protocol_next = data_byte;
    end
    // TCP fields sit relative to the start captured at the IHL byte
    if (byte_offset > LENGTH_BITS'(OFF_IHL)) begin
      if (byte_offset == tcp_base + LENGTH_BITS'(TCP_DOFF_OFF)) begin
        tcp_header_words_next = data_byte[7:4];
      end else if (byte_offset == tcp_base + LENGTH_BITS'(TCP_FLAGS_OFF)) begin
        tcp_flag_bits_next = data_byte;
      end
    end
  end

  assign tcp_base = LENGTH_BITS'(tcp_start_offset);
  assign len      = (byte_offset != LEN_MAX) ? byte_offset + 1'b1 : LEN_MAX;

  assign ip_end      = LENGTH_BITS'(ETH_HDR_BYTES) + LENGTH_BITS'({ip_header_words_next, 2'b00});
  assign tcp_min_end = LENGTH_BITS'(tcp_start_offset_next) + LENGTH_BITS'(TCP_MIN_BYTES);
  assign tcp_end     = LENGTH_BITS'(tcp_start_offset_next)
                     + LENGTH_BITS'({tcp_header_words_next, 2'b00});

  always_comb begin
    reason = REASON_PASS;
    if (len >= LENGTH_BITS'(ETH_HDR_BYTES) && ether_type_next == ETHERTYPE_IPV4 &&
        len >= LENGTH_BITS'(IP_MIN_END) && ip_header_words_next >= MIN_HDR_WORDS &&
        ip_end <= len && ip_protocol_next == IP_PROTO_TCP &&
        tcp_min_end <= len && tcp_header_words_next >= MIN_HDR_WORDS &&
        tcp_end <= len) begin
      if (tcp_flag_bits_next[FLAG_SYN] && tcp_flag_bits_next[FLAG_ACK]) begin
        reason = REASON_SYNACK;
      end else if (tcp_flag_bits_next[FLAG_RST]) begin
        reason = REASON_RST;
      end
    end
  end

  assign verdict_reason = reason;
  assign verdict_len    = len;

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_offset      <= '0;
      ether_type       <= '0;
      ip_header_words  <= '0;
      ip_protocol      <= '0;
      tcp_start_offset <= '0;
      tcp_header_words <= '0;
      tcp_flag_bits    <= '0;
    end else if (accept) begin
      byte_offset      <= len;
      ether_type       <= ether_type_next;
      ip_header_words  <= ip_header_words_next;
      ip_protocol      <= ip_protocol_next;
      tcp_start_offset <= tcp_start_offset_next;
      tcp_header_words <= tcp_header_words_next;
      tcp_flag_bits    <= tcp_flag_bits_next;
    end
  end

endmodule

### hw/rtl/tsrdf_queue.sv
// Small register FIFO between the parser and the counter unit
module tsrdf_queue import tsrdf_pkg::*; #(
  parameter int WIDTH = REASON_BITS + DEFAULT_LENGTH_BITS,
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_word,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_word
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push, do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_word   = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/tsrdf_counter_unit.sv
// Back end: running counters and the registered result word
module tsrdf_counter_unit import tsrdf_pkg::*; #(
  parameter int LENGTH_BITS  = DEFAULT_LENGTH_BITS,
  parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    verdict_valid,
  output logic                    verdict_ready,
  input  logic [REASON_BITS-1:0]  verdict_reason,
  input  logic [LENGTH_BITS-1:0]  verdict_len,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic                    drop,
  output logic [REASON_BITS-1:0]  drop_reason,
  output logic [LENGTH_BITS-1:0]  frame_bytes,
  output logic [COUNTER_BITS-1:0] packets_dropped,
  output logic [COUNTER_BITS-1:0] packets_passed,
  output logic [COUNTER_BITS-1:0] bytes_dropped,
  output logic [COUNTER_BITS-1:0] bytes_passed,
  output logic [COUNTER_BITS-1:0] synack_drops,
  output logic [COUNTER_BITS-1:0] rst_drops
);

  logic load;
  logic is_drop;

  // counters only move on load, so they double as the result fields
  assign verdict_ready = !result_valid || result_ready;
  assign load          = verdict_valid && verdict_ready;
  assign is_drop       = (verdict_reason != REASON_PASS);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid    <= 1'b0;
      packets_dropped <= '0;
      packets_passed  <= '0;
      bytes_dropped   <= '0;
      bytes_passed    <= '0;
      synack_drops    <= '0;
      rst_drops       <= '0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (load) begin
        if (is_drop) begin
          packets_dropped <= packets_dropped + 1'b1;
          bytes_dropped   <= bytes_dropped + COUNTER_BITS'(verdict_len);
          if (verdict_reason == REASON_SYNACK) begin
            synack_drops <= synack_drops + 1'b1;
          end else begin
            rst_drops <= rst_drops + 1'b1;
          end
        end else begin
          packets_passed <= packets_passed + 1'b1;
          bytes_passed   <= bytes_passed + COUNTER_BITS'(verdict_len);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drop        <= is_drop;
      drop_reason <= verdict_reason;
      frame_bytes <= verdict_len;
    end
  end

endmodule

### hw/rtl/tcp_synack_rst_drop_filter_unit.sv
// Top level of the TCP SYN-ACK / RST drop filter
//
// Input channel (byte_valid/byte_ready): one Ethernet frame byte per word,
// starting at the destination address; last_byte marks the frame end.
// Output channel (result_valid/result_ready): one word per frame, the
// drop verdict, its reason, the frame length (saturating) and six running
// counters that include this frame.
// Throughput: one byte per cycle while the queue has room. The parser decides at
// the last byte and the verdict enters a small queue; the counter unit loads
// the result register from the queue, so a verdict passes the queue and then
// the result register before it appears as a result.
// Stall: while the result waits, the queue keeps filling; byte_ready drops
// only once the queue is full, so bytes stop only after that many frames.
// Reset: synchronous, clears per-frame state, queue and all counters.
`include "tcp_synack_rst_drop_filter_unit_defines.svh"

module tcp_synack_rst_drop_filter_unit import tsrdf_pkg::*; #(
  parameter int LENGTH_BITS  = DEFAULT_LENGTH_BITS,
  parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS,
  parameter int QUEUE_DEPTH  = DEFAULT_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  output logic                    byte_ready,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic                    drop,
  output logic [REASON_BITS-1:0]  drop_reason,
  output logic [LENGTH_BITS-1:0]  frame_bytes,
  output logic [COUNTER_BITS-1:0] packets_dropped,
  output logic [COUNTER_BITS-1:0] packets_passed,
  output logic [COUNTER_BITS-1:0] bytes_dropped,
  output logic [COUNTER_BITS-1:0] bytes_passed,
  output logic [COUNTER_BITS-1:0] synack_drops,
  output logic [COUNTER_BITS-1:0] rst_drops
);

  localparam int WORD_BITS = REASON_BITS + LENGTH_BITS;

  logic                   pv_valid, pv_ready;
  logic [REASON_BITS-1:0] pv_reason;
  logic [LENGTH_BITS-1:0] pv_len;
  logic                   qv_valid, qv_ready;
  logic [WORD_BITS-1:0]   qv_word;

  tsrdf_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .verdict_valid (pv_valid),
    .verdict_ready (pv_ready),
    .verdict_reason(pv_reason),
    .verdict_len   (pv_len)
  );

  tsrdf_queue #(
    .WIDTH(WORD_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(pv_valid),
    .push_ready(pv_ready),
    .push_word ({pv_reason, pv_len}),
    .pop_valid (qv_valid),
    .pop_ready (qv_ready),
    .pop_word  (qv_word)
  );

  tsrdf_counter_unit #(
    .LENGTH_BITS (LENGTH_BITS),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_counters (
    .clk            (clk),
    .rst            (rst),
    .verdict_valid  (qv_valid),
    .verdict_ready  (qv_ready),
    .verdict_reason (qv_word[WORD_BITS-1:LENGTH_BITS]),
    .verdict_len    (qv_word[LENGTH_BITS-1:0]),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .drop           (drop),
    .drop_reason    (drop_reason),
    .frame_bytes    (frame_bytes),
    .packets_dropped(packets_dropped),
    .packets_passed (packets_passed),
    .bytes_dropped  (bytes_dropped),
    .bytes_passed   (bytes_passed),
    .synack_drops   (synack_drops),
    .rst_drops      (rst_drops)
  );

  // each verdict taken by the back end bumps exactly one packet counter
  `TSRDF_ASSERT_NEXT(a_one_packet_per_verdict, clk, rst, qv_valid && qv_ready, COUNTER_BITS'(packets_dropped + packets_passed) == COUNTER_BITS'($past(packets_dropped + packets_passed) + 1'b1), "packet counters did not advance by one")
  // drop counters split exactly into the two reasons
  `TSRDF_ASSERT_SAME(a_drop_split, clk, rst, 1'b1, COUNTER_BITS'(synack_drops + rst_drops) == packets_dropped, "reason counters disagree with drop count")
  // drop flag and reason code agree on a presented result
  `TSRDF_ASSERT_SAME(a_drop_reason, clk, rst, result_valid, drop == (drop_reason != REASON_PASS), "drop flag disagrees with reason")

endmodule
